>>> rtl/stream_receive_reassembly_tracker_top_assert.svh
// Assertion macros for the stream receive tracker checker.
`ifndef STREAM_RECEIVE_REASSEMBLY_TRACKER_TOP_ASSERT_SVH
`define STREAM_RECEIVE_REASSEMBLY_TRACKER_TOP_ASSERT_SVH

// Overlapping implication: cond implies prop in the same cycle.
`define SRRT_ASSERT_NOW(lbl, clk, rstn, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
    else $error("srrt assertion failed");

// Non-overlapping implication: cond implies prop in the next cycle.
`define SRRT_ASSERT_NEXT(lbl, clk, rstn, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
    else $error("srrt assertion failed");

`endif

>>> rtl/srrt_pkg.sv
package srrt_pkg;

  localparam logic [61:0] WindowReset = 62'd1048576;

  typedef enum logic [2:0] {
    K_DELIVER    = 3'd0,
    K_BUFFERED   = 3'd1,
    K_UNTRACKED  = 3'd2,
    K_FLOW_ERR   = 3'd3,
    K_CONN_LIM   = 3'd4,
    K_STREAM_LIM = 3'd5,
    K_END        = 3'd6,
    K_NOTHING    = 3'd7
  } kind_e;

  typedef struct packed {
    logic load;
    logic set_fin;
    logic deliver;
    logic rec_init;
    logic rec_step;
    logic rec_finish;
    logic pop;
    logic raise_conn;
    logic raise_stream;
  } cmd_t;

  typedef struct packed {
    logic flow_err;
    logic ahead;
    logic grows_point;
    logic fin;
    logic full;
    logic rec_done;
    logic head_ready;
    logic head_adds;
    logic conn_low;
    logic stream_low;
    logic at_end;
  } status_t;

endpackage

>>> rtl/srrt_dp.sv
module srrt_dp #(
  parameter int GAP_SLOTS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_wdata_i,
  input  logic [61:0]      frame_offset_i,
  input  logic [15:0]      frame_length_i,
  input  logic             frame_fin_i,
  input  srrt_pkg::cmd_t   cmd_i,
  output srrt_pkg::status_t status_o
);

  localparam int CW = $clog2(GAP_SLOTS + 1);
  localparam int IW = (GAP_SLOTS > 1) ? $clog2(GAP_SLOTS) : 1;
  localparam logic [CW-1:0] Slots = CW'(GAP_SLOTS);

  logic [61:0] off_q;
  logic [15:0] len_q;
  logic        fin_q;
  logic [61:0] inorder_q, slim_q, clim_q, final_q;
  logic        fin_seen_q;
  logic [31:0] win_q;
  logic [CW-1:0] cnt_q, rem_q, wr_q;
  logic        fed_q, accv_q;
  logic [61:0] acc_start_q;
  logic [62:0] acc_end_q;
  logic [61:0] start_q [GAP_SLOTS];
  logic [31:0] size_q  [GAP_SLOTS];

  logic [62:0] end_w, head_end, s_end, bound, raised;
  logic [61:0] s_start, raised_sat;
  logic [29:0] low;
  logic        feed_n, merge, shift, we;
  logic [CW-1:0] step_idx, widx;

  assign end_w    = {1'b0, off_q} + 63'(len_q);
  assign head_end = {1'b0, start_q[0]} + 63'(size_q[0]);
  assign low      = win_q[31:2];
  assign bound    = {1'b0, inorder_q} + 63'(low);
  assign raised   = {1'b0, inorder_q} + 63'(win_q);
  assign raised_sat = raised[62] ? {62{1'b1}} : raised[61:0];

  // merge-insert pass: feed the new range before the first slot that starts after it
  assign feed_n  = !fed_q && ((rem_q == '0) || (start_q[0] > off_q));
  assign s_start = feed_n ? off_q : start_q[0];
  assign s_end   = feed_n ? end_w : head_end;
  assign merge   = accv_q && (acc_end_q >= {1'b0, s_start});
  assign shift   = !feed_n;
  assign step_idx = rem_q + wr_q - CW'(shift);
  assign we      = (cmd_i.rec_step && accv_q && !merge) || cmd_i.rec_finish;
  assign widx    = cmd_i.rec_finish ? wr_q : step_idx;

  always_comb begin
    status_o.flow_err    = end_w > {1'b0, slim_q};
    status_o.ahead       = off_q > inorder_q;
    status_o.grows_point = end_w > {1'b0, inorder_q};
    status_o.fin         = fin_q;
    status_o.full        = cnt_q == Slots;
    status_o.rec_done    = fed_q && (rem_q == '0);
    status_o.head_ready  = (cnt_q != '0) && (start_q[0] <= inorder_q);
    status_o.head_adds   = head_end > {1'b0, inorder_q};
    status_o.conn_low    = (low != '0) && ({1'b0, clim_q} < bound);
    status_o.stream_low  = (low != '0) && ({1'b0, slim_q} < bound);
    status_o.at_end      = fin_seen_q && (inorder_q >= final_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      off_q <= frame_offset_i;
      len_q <= frame_length_i;
      fin_q <= frame_fin_i;
    end
    if (cmd_i.rec_step) begin
      if (merge) begin
        if (s_end > acc_end_q) acc_end_q <= s_end;
      end else begin
        acc_start_q <= s_start;
        acc_end_q   <= s_end;
      end
    end
    if (cmd_i.pop || (cmd_i.rec_step && shift)) begin
      for (int k = 0; k < GAP_SLOTS - 1; k++) begin
        start_q[k] <= start_q[k+1];
        size_q[k]  <= size_q[k+1];
      end
    end
    if (we) begin
      start_q[widx[IW-1:0]] <= acc_start_q;
      size_q[widx[IW-1:0]]  <= 32'(acc_end_q - {1'b0, acc_start_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inorder_q  <= '0;
      slim_q     <= srrt_pkg::WindowReset;
      clim_q     <= srrt_pkg::WindowReset;
      final_q    <= '0;
      fin_seen_q <= 1'b0;
      win_q      <= 32'(srrt_pkg::WindowReset);
      cnt_q      <= '0;
      rem_q      <= '0;
      wr_q       <= '0;
      fed_q      <= 1'b0;
      accv_q     <= 1'b0;
    end else begin
      if (cfg_we_i) win_q <= cfg_wdata_i;
      if (cmd_i.set_fin) begin
        fin_seen_q <= 1'b1;
        final_q    <= end_w[61:0];
      end
      if (cmd_i.deliver) inorder_q <= end_w[61:0];
      if (cmd_i.pop) begin
        cnt_q <= cnt_q - CW'(1);
        if (status_o.head_adds) inorder_q <= head_end[61:0];
      end
      if (cmd_i.rec_init) begin
        rem_q  <= cnt_q;
        wr_q   <= '0;
        fed_q  <= 1'b0;
        accv_q <= 1'b0;
      end
      if (cmd_i.rec_step) begin
        if (feed_n) fed_q <= 1'b1;
        else        rem_q <= rem_q - CW'(1);
        if (we)     wr_q  <= wr_q + CW'(1);
        accv_q <= 1'b1;
      end
      if (cmd_i.rec_finish) cnt_q <= wr_q + CW'(1);
      // the connection limit is raised to the in-order point plus the window, saturated
      if (cmd_i.raise_conn)   clim_q <= raised_sat;
      if (cmd_i.raise_stream) slim_q <= raised_sat;
    end
  end

endmodule

>>> rtl/srrt_ctrl.sv
module srrt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        kind_o,
  input  srrt_pkg::status_t status_i,
  output srrt_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_REC, S_DRAIN, S_LIMC, S_LIMS, S_ENDC
  } state_e;

  state_e state_q, state_d;
  logic   path_q, path_d;
  logic   out_valid_q, out_valid_d;
  srrt_pkg::kind_e kind_q, kind_d;
  logic   out_free, emit;
  srrt_pkg::kind_e ekind;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;

  always_comb begin
    state_d = state_q;
    path_d  = path_q;
    cmd_o   = '0;
    emit    = 1'b0;
    ekind   = srrt_pkg::K_DELIVER;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (out_free) begin
          path_d = !status_i.ahead;
          if (status_i.flow_err) begin
            emit = 1'b1; ekind = srrt_pkg::K_FLOW_ERR; state_d = S_IDLE;
          end else begin
            cmd_o.set_fin = status_i.fin;
            if (status_i.ahead) begin
              if (status_i.full) begin
                emit = 1'b1; ekind = srrt_pkg::K_UNTRACKED; state_d = S_LIMC;
              end else begin
                cmd_o.rec_init = 1'b1; state_d = S_REC;
              end
            end else if (status_i.grows_point) begin
              cmd_o.deliver = 1'b1;
              emit = 1'b1; ekind = srrt_pkg::K_DELIVER; state_d = S_DRAIN;
            end else begin
              emit = 1'b1; ekind = srrt_pkg::K_NOTHING; state_d = S_LIMC;
            end
          end
        end
      end
      S_REC: begin
        if (!status_i.rec_done) begin
          cmd_o.rec_step = 1'b1;
        end else if (out_free) begin
          cmd_o.rec_finish = 1'b1;
          emit = 1'b1; ekind = srrt_pkg::K_BUFFERED; state_d = S_LIMC;
        end
      end
      S_DRAIN: begin
        if (!status_i.head_ready) begin
          state_d = S_LIMC;
        end else if (!status_i.head_adds) begin
          cmd_o.pop = 1'b1;
        end else if (out_free) begin
          cmd_o.pop = 1'b1;
          emit = 1'b1; ekind = srrt_pkg::K_DELIVER;
        end
      end
      S_LIMC: begin
        if (!status_i.conn_low) begin
          state_d = S_LIMS;
        end else if (out_free) begin
          cmd_o.raise_conn = 1'b1;
          emit = 1'b1; ekind = srrt_pkg::K_CONN_LIM; state_d = S_LIMS;
        end
      end
      S_LIMS: begin
        if (!status_i.stream_low) begin
          state_d = path_q ? S_ENDC : S_IDLE;
        end else if (out_free) begin
          cmd_o.raise_stream = 1'b1;
          emit = 1'b1; ekind = srrt_pkg::K_STREAM_LIM;
          state_d = path_q ? S_ENDC : S_IDLE;
        end
      end
      S_ENDC: begin
        if (!status_i.at_end) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          emit = 1'b1; ekind = srrt_pkg::K_END; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    if (emit) begin
      out_valid_d = 1'b1;
      kind_d      = ekind;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      path_q      <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= srrt_pkg::K_DELIVER;
    end else begin
      state_q     <= state_d;
      path_q      <= path_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
    end
  end

endmodule

>>> rtl/stream_receive_reassembly_tracker_top.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   frame_offset_i, frame_length_i, frame_fin_i
// out      output     out_valid_o / out_stall_i kind_o
// cfg      input      cfg_we_i                  cfg_wdata_i (window size)
//
// One frame at a time; output stalls can hold a frame in progress.
// The range table merge-insert pass takes one slot per cycle, the drain one per unstalled cycle.
// A new frame can be taken in the first cycle in which the controller is back in idle.
// Reset clears all counters and sets the limits and window to WindowReset; the range table needs no clearing.
// Output stalls hold the controller only in steps that may produce a result.
module stream_receive_reassembly_tracker_top #(
  parameter int GAP_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [61:0] frame_offset_i,
  input  logic [15:0] frame_length_i,
  input  logic        frame_fin_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o
);

  srrt_pkg::cmd_t    cmd;
  srrt_pkg::status_t status;

  srrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  srrt_dp #(.GAP_SLOTS(GAP_SLOTS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .frame_offset_i (frame_offset_i),
    .frame_length_i (frame_length_i),
    .frame_fin_i    (frame_fin_i),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule

>>> rtl/srrt_chk.sv
`include "stream_receive_reassembly_tracker_top_assert.svh"

module srrt_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [61:0] frame_offset_i,
  input logic [15:0] frame_length_i,
  input logic        frame_fin_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  kind_o
);

  // stalled result holds
  `SRRT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(kind_o))
  // stalled frame holds
  `SRRT_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable({frame_offset_i, frame_length_i, frame_fin_i}))
  // one frame at a time: busy right after a transaction is taken
  `SRRT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  // no result is loaded on the edge that takes a frame
  `SRRT_ASSERT_NEXT(a_no_result_on_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, !$rose(out_valid_o))

endmodule

bind stream_receive_reassembly_tracker_top srrt_chk u_srrt_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .frame_offset_i (frame_offset_i),
  .frame_length_i (frame_length_i),
  .frame_fin_i    (frame_fin_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .kind_o         (kind_o)
);
